/* rtl/core/rrts_pkg.sv */
`default_nettype none

package rrts_pkg;

  localparam int NUM_TASKS = 8;
  localparam int TASK_W    = 3;

  // frame layout below the top of a new stack
  localparam logic [15:0] FRAME_BYTES = 16'd2;
  localparam logic [15:0] REG_SPACE   = 16'd18;

  localparam logic OP_YIELD  = 1'b0;
  localparam logic OP_CREATE = 1'b1;

  localparam logic ST_OK   = 1'b0;
  localparam logic ST_FULL = 1'b1;

  typedef struct packed {
    logic        operation;
    logic [15:0] current_sp;
    logic [15:0] stack_base;
    logic [15:0] stack_size;
    logic [15:0] entry_addr;
  } rrts_in_t;

  typedef struct packed {
    logic        status;
    logic [2:0]  task_index;
    logic [15:0] next_sp;
    logic        write_frame;
    logic [15:0] frame_top;
  } rrts_out_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic exec;
    logic fetch;
    logic load;
  } rrts_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_yield;
    logic out_free;
  } rrts_stat_t;

endpackage

`default_nettype wire

/* rtl/core/rrts_ctrl.sv */
`default_nettype none

module rrts_ctrl import rrts_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire rrts_stat_t stat,
  output rrts_cmd_t       cmd
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_EXEC  = 4'b0010,
    S_FETCH = 4'b0100,
    S_LOAD  = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    in_ready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.exec    = 1'b0;
    cmd.fetch   = 1'b0;
    cmd.load    = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
        if (in_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = stat.is_yield ? S_FETCH : S_LOAD;
      end
      S_FETCH: begin
        cmd.fetch  = 1'b1;
        state_next = S_LOAD;
      end
      S_LOAD: begin
        if (stat.out_free) begin
          cmd.load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/core/rrts_dp.sv */
`default_nettype none

module rrts_dp import rrts_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire rrts_in_t  in_data,
  input  wire rrts_cmd_t cmd,
  output rrts_stat_t     stat,
  output logic           out_valid,
  input  wire logic      out_ready,
  output rrts_out_t      out_data
);

  rrts_in_t                item;
  logic [NUM_TASKS-1:0]    alive;
  logic [TASK_W-1:0]       cur;
  logic [15:0]             sp_mem [NUM_TASKS];
  rrts_out_t               res;

  logic [TASK_W-1:0]       rr_pick;
  logic [TASK_W-1:0]       free_slot;
  logic                    free_found;
  logic [TASK_W:0]         rr_sum;
  logic [TASK_W-1:0]       rr_idx;
  logic [15:0]             top;
  logic [15:0]             init_sp;

  assign stat.is_yield = (item.operation == OP_YIELD);
  assign stat.out_free = !out_valid || out_ready;

  // next alive slot after the current one, nearest first
  always_comb begin
    rr_pick = cur;
    rr_sum  = '0;
    rr_idx  = '0;
    for (int i = NUM_TASKS - 1; i >= 1; i--) begin
      rr_sum = {1'b0, cur} + (TASK_W+1)'(i);
      if (rr_sum >= (TASK_W+1)'(NUM_TASKS)) begin
        rr_sum = rr_sum - (TASK_W+1)'(NUM_TASKS);
      end
      rr_idx = rr_sum[TASK_W-1:0];
      if (alive[rr_idx]) begin
        rr_pick = rr_idx;
      end
    end
  end

  // lowest slot not alive
  always_comb begin
    free_slot  = '0;
    free_found = 1'b0;
    for (int i = NUM_TASKS - 1; i >= 0; i--) begin
      if (!alive[i]) begin
        free_slot  = TASK_W'(i);
        free_found = 1'b1;
      end
    end
  end

  assign top     = item.stack_base + item.stack_size - 16'd1;
  assign init_sp = top - FRAME_BYTES - REG_SPACE;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item <= in_data;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      alive <= NUM_TASKS'(1);
      cur   <= '0;
    end else if (cmd.exec) begin
      if (item.operation == OP_YIELD) begin
        cur <= rr_pick;
      end else if (free_found) begin
        alive[free_slot] <= 1'b1;
      end
    end
  end

  // saved pointer table, read registered into the result
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      if (item.operation == OP_YIELD) begin
        sp_mem[cur] <= item.current_sp;
      end else if (free_found) begin
        sp_mem[free_slot] <= init_sp;
      end
    end
    if (cmd.fetch) begin
      res.next_sp <= sp_mem[res.task_index];
    end
    if (cmd.exec) begin
      if (item.operation == OP_YIELD) begin
        res.status      <= ST_OK;
        res.task_index  <= rr_pick;
        res.write_frame <= 1'b0;
        res.frame_top   <= '0;
      end else if (free_found) begin
        res.status      <= ST_OK;
        res.task_index  <= free_slot;
        res.next_sp     <= init_sp;
        res.write_frame <= 1'b1;
        res.frame_top   <= top;
      end else begin
        res.status      <= ST_FULL;
        res.task_index  <= '0;
        res.next_sp     <= '0;
        res.write_frame <= 1'b0;
        res.frame_top   <= '0;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_data <= res;
    end
  end

`ifndef SYNTHESIS
  a_slot0_alive: assert property (@(posedge clk) disable iff (rst) alive[0])
    else $error("slot zero lost its alive bit");

  a_cur_alive: assert property (@(posedge clk) disable iff (rst) alive[cur])
    else $error("current task is not alive");

  a_create_claims: assert property (@(posedge clk) disable iff (rst)
    cmd.exec && item.operation == OP_CREATE && free_found |=> alive[$past(free_slot)])
    else $error("create did not claim its slot");

  a_no_load_over: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> !out_valid || out_ready)
    else $error("result loaded over an untaken result");
`endif

endmodule

`default_nettype wire

/* rtl/core/round_robin_task_switcher.sv */
`default_nettype none

// round-robin task switcher
// input channel: in_valid / in_ready / in_data, one item per transfer
//   operation yield: saves current_sp for the running task, moves to the
//   next alive slot in round-robin order and returns its saved pointer
//   operation create: claims the lowest free slot, sets its initial pointer
//   and asks for a two-byte frame write at frame_top and frame_top - 1
// output channel: out_valid / out_ready / out_data, one result per item
// a yield result is registered through the execute, table read and load
//   steps after the capture, a create result through the execute and load
//   steps, as the controller walks them
// one item in flight: the next item is taken only once the last result is
//   loaded, set by the controller sequence and the registered table read
// the output register holds a finished result, so the next item is taken
//   while the receiver stalls; the load step waits until the register frees
// reset: slot zero alive and current, all other slots free, no result held

module round_robin_task_switcher import rrts_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire rrts_in_t in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output rrts_out_t     out_data
);

  rrts_cmd_t  cmd;
  rrts_stat_t stat;

  // sequencer: one step per cycle through each item, the load step waiting while the output register is full
  rrts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // task table, slot search, pointer arithmetic and output register
  rrts_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
